// ----- sv/icd_pkg.sv -----
package icd_pkg;

    localparam int COORD_BITS    = 13;
    localparam int FRAC_BITS     = 8;
    localparam int POS_BITS      = COORD_BITS + FRAC_BITS;
    localparam int SPEED_BITS    = 32;
    localparam int TD_BITS       = 16;
    localparam int GAIN_BITS     = 16;
    localparam int DRAG_BITS     = 16;
    localparam int IMP_BITS      = 16;
    localparam int RECT_BITS     = 12;
    localparam int RECT_ALL_BITS = 4 * RECT_BITS;
    localparam int MAG_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS     = MAG_BITS + TD_BITS;
    localparam int FULL_BITS     = PROD_BITS + GAIN_BITS;
    localparam int ACC_BITS      = FULL_BITS - FRAC_BITS;
    localparam int SUM_BITS      = ((SPEED_BITS > ACC_BITS) ? SPEED_BITS : ACC_BITS + 1) + 1;
    localparam int PSUM_BITS     = ((POS_BITS > SPEED_BITS) ? POS_BITS : SPEED_BITS) + 1;
    localparam int NUM_AXES      = 2;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = RECT_ALL_BITS;

    localparam logic [OP_BITS-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_BITS-1:0] OP_IMPULSE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TELEPORT = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PHYSICS_ENABLE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUNDS_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_GAIN     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_STEP      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIENT_RECT    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUNDS_RECT    = 3'd5;

    localparam logic [GAIN_BITS-1:0]     GAIN_RESET = 16'd655;
    localparam logic [DRAG_BITS-1:0]     DRAG_RESET = 16'd256;
    localparam logic [RECT_ALL_BITS-1:0] RECT_RESET = 48'h2FF3FF000000;

    typedef struct packed {
        logic                     physics_enable;
        logic                     bounds_enable;
        logic [GAIN_BITS-1:0]     accel_gain;
        logic [DRAG_BITS-1:0]     drag_step;
        logic [RECT_ALL_BITS-1:0] client_rect;
        logic [RECT_ALL_BITS-1:0] bounds_rect;
    } t_cfg;

    typedef struct packed {
        logic start_mul;
        logic pass;
        logic impulse;
        logic teleport;
        logic mul2;
        logic acc;
        logic upd;
        logic load_out;
        logic upd_last;
    } t_cmd;

    function automatic logic signed [SPEED_BITS-1:0] sat_speed(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-SPEED_BITS:0] top;
        logic                          ovf;
        top = v[SUM_BITS-1:SPEED_BITS-1];
        ovf = !((&top) || !(|top));
        if (ovf) begin
            sat_speed = v[SUM_BITS-1] ? {1'b1, {(SPEED_BITS-1){1'b0}}}
                                      : {1'b0, {(SPEED_BITS-1){1'b1}}};
        end else begin
            sat_speed = v[SPEED_BITS-1:0];
        end
    endfunction

endpackage

// ----- sv/icd_cfg.sv -----
module icd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [icd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [icd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output icd_pkg::t_cfg                    o_cfg
);
    import icd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.physics_enable <= 1'b0;
            r_cfg.bounds_enable  <= 1'b0;
            r_cfg.accel_gain     <= GAIN_RESET;
            r_cfg.drag_step      <= DRAG_RESET;
            r_cfg.client_rect    <= RECT_RESET;
            r_cfg.bounds_rect    <= RECT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PHYSICS_ENABLE: r_cfg.physics_enable <= i_cfg_data[0];
                CFG_BOUNDS_ENABLE:  r_cfg.bounds_enable  <= i_cfg_data[0];
                CFG_ACCEL_GAIN:     r_cfg.accel_gain     <= i_cfg_data[GAIN_BITS-1:0];
                CFG_DRAG_STEP:      r_cfg.drag_step      <= i_cfg_data[DRAG_BITS-1:0];
                CFG_CLIENT_RECT:    r_cfg.client_rect    <= i_cfg_data;
                CFG_BOUNDS_RECT:    r_cfg.bounds_rect    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ----- sv/icd_ctrl.sv -----
module icd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [icd_pkg::OP_BITS-1:0] i_op,
    input  logic                        i_physics_enable,
    output icd_pkg::t_cmd               o_cmd
);
    import icd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_UPD  = 5'b01000,
        S_RES  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_is_tick, n_is_tick;

    always_comb begin
        n_state   = r_state;
        n_is_tick = r_is_tick;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_is_tick = (i_op == OP_TICK);
                    n_state   = S_RES;
                    unique case (i_op)
                        OP_TICK: begin
                            if (i_physics_enable) begin
                                o_cmd.start_mul = 1'b1;
                                n_state         = S_MUL;
                            end else begin
                                o_cmd.pass = 1'b1;
                            end
                        end
                        OP_IMPULSE:  o_cmd.impulse  = 1'b1;
                        OP_TELEPORT: o_cmd.teleport = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.upd_last = r_is_tick;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_is_tick   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_is_tick   <= n_is_tick;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/icd_dp.sv -----
module icd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  icd_pkg::t_cfg                       i_cfg,
    input  icd_pkg::t_cmd                       i_cmd,
    input  logic [icd_pkg::TD_BITS-1:0]         i_time_diff,
    input  logic signed [icd_pkg::COORD_BITS-1:0] i_pointer_x,
    input  logic signed [icd_pkg::COORD_BITS-1:0] i_pointer_y,
    input  logic signed [icd_pkg::IMP_BITS-1:0]   i_impulse_x,
    input  logic signed [icd_pkg::IMP_BITS-1:0]   i_impulse_y,
    output logic signed [icd_pkg::COORD_BITS-1:0] o_cursor_x,
    output logic signed [icd_pkg::COORD_BITS-1:0] o_cursor_y,
    output logic                                o_moving
);
    import icd_pkg::*;

    logic signed [POS_BITS-1:0]   r_pos   [NUM_AXES];
    logic signed [SPEED_BITS-1:0] r_speed [NUM_AXES];
    logic signed [COORD_BITS-1:0] r_last  [NUM_AXES];
    logic                         r_neg   [NUM_AXES];
    logic [PROD_BITS-1:0]         r_prod  [NUM_AXES];
    logic [ACC_BITS-1:0]          r_acc   [NUM_AXES];
    logic signed [COORD_BITS-1:0] r_cur   [NUM_AXES];
    logic                         r_moving;

    logic [RECT_ALL_BITS-1:0]     rect;
    logic [RECT_BITS-1:0]         lo      [NUM_AXES];
    logic [RECT_BITS-1:0]         hi      [NUM_AXES];
    logic signed [COORD_BITS-1:0] ptr     [NUM_AXES];
    logic signed [IMP_BITS-1:0]   imp     [NUM_AXES];
    logic signed [MAG_BITS-1:0]   delta   [NUM_AXES];
    logic [MAG_BITS-1:0]          mag     [NUM_AXES];
    logic [PROD_BITS-1:0]         prod    [NUM_AXES];
    logic [FULL_BITS-1:0]         full    [NUM_AXES];
    logic signed [SUM_BITS-1:0]   spd_ext [NUM_AXES];
    logic signed [SUM_BITS-1:0]   acc_ext [NUM_AXES];
    logic signed [SUM_BITS-1:0]   ssum    [NUM_AXES];
    logic signed [SUM_BITS-1:0]   isum    [NUM_AXES];
    logic signed [PSUM_BITS-1:0]  psum    [NUM_AXES];
    logic signed [PSUM_BITS-1:0]  lo_fx   [NUM_AXES];
    logic signed [PSUM_BITS-1:0]  hi_fx   [NUM_AXES];
    logic signed [PSUM_BITS-1:0]  clamped [NUM_AXES];
    logic signed [SPEED_BITS:0]   spd1    [NUM_AXES];
    logic signed [SPEED_BITS:0]   d_ext   [NUM_AXES];
    logic signed [SPEED_BITS:0]   dsum    [NUM_AXES];
    logic signed [SPEED_BITS-1:0] dragged [NUM_AXES];
    logic signed [POS_BITS-1:0]   rnd     [NUM_AXES];
    logic signed [COORD_BITS-1:0] cur_int [NUM_AXES];

    always_comb begin
        rect   = i_cfg.bounds_enable ? i_cfg.bounds_rect : i_cfg.client_rect;
        lo[0]  = rect[RECT_BITS-1:0];
        lo[1]  = rect[2*RECT_BITS-1:RECT_BITS];
        hi[0]  = rect[3*RECT_BITS-1:2*RECT_BITS];
        hi[1]  = rect[4*RECT_BITS-1:3*RECT_BITS];
        ptr[0] = i_pointer_x;
        ptr[1] = i_pointer_y;
        imp[0] = i_impulse_x;
        imp[1] = i_impulse_y;
        for (int a = 0; a < NUM_AXES; a++) begin
            // acceleration magnitude, first product taken at accept
            delta[a] = {r_last[a][COORD_BITS-1], r_last[a]}
                     - {ptr[a][COORD_BITS-1], ptr[a]};
            mag[a]   = delta[a][MAG_BITS-1] ? $unsigned(-delta[a]) : $unsigned(delta[a]);
            prod[a]  = PROD_BITS'(mag[a]) * PROD_BITS'(i_time_diff);
            full[a]  = FULL_BITS'(r_prod[a]) * FULL_BITS'(i_cfg.accel_gain);

            spd_ext[a] = {{(SUM_BITS-SPEED_BITS){r_speed[a][SPEED_BITS-1]}}, r_speed[a]};
            acc_ext[a] = {{(SUM_BITS-ACC_BITS){1'b0}}, r_acc[a]};
            ssum[a]    = r_neg[a] ? spd_ext[a] + acc_ext[a] : spd_ext[a] - acc_ext[a];
            isum[a]    = spd_ext[a] + {{(SUM_BITS-IMP_BITS){imp[a][IMP_BITS-1]}}, imp[a]};

            // move and clamp, left or top wins when the rectangle is inverted
            psum[a]  = {{(PSUM_BITS-POS_BITS){r_pos[a][POS_BITS-1]}}, r_pos[a]}
                     + {{(PSUM_BITS-SPEED_BITS){r_speed[a][SPEED_BITS-1]}}, r_speed[a]};
            lo_fx[a] = {{(PSUM_BITS-RECT_BITS-FRAC_BITS){1'b0}}, lo[a], {FRAC_BITS{1'b0}}};
            hi_fx[a] = {{(PSUM_BITS-RECT_BITS-FRAC_BITS){1'b0}}, hi[a], {FRAC_BITS{1'b0}}};
            if (psum[a] < lo_fx[a] || hi_fx[a] < lo_fx[a]) begin
                clamped[a] = lo_fx[a];
            end else if (psum[a] > hi_fx[a]) begin
                clamped[a] = hi_fx[a];
            end else begin
                clamped[a] = psum[a];
            end

            // drag toward zero without crossing it
            spd1[a]  = {r_speed[a][SPEED_BITS-1], r_speed[a]};
            d_ext[a] = {{(SPEED_BITS+1-DRAG_BITS){1'b0}}, i_cfg.drag_step};
            dsum[a]  = r_speed[a][SPEED_BITS-1] ? spd1[a] + d_ext[a] : spd1[a] - d_ext[a];
            if (r_speed[a] == '0
                || (r_speed[a][SPEED_BITS-1] && dsum[a] > 0)
                || (!r_speed[a][SPEED_BITS-1] && dsum[a] < 0)) begin
                dragged[a] = '0;
            end else begin
                dragged[a] = dsum[a][SPEED_BITS-1:0];
            end

            // integer part, rounded toward zero
            rnd[a]     = r_pos[a]
                       + {{(POS_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{r_pos[a][POS_BITS-1]}}};
            cur_int[a] = rnd[a][POS_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_pos[a]   <= '0;
                r_speed[a] <= '0;
                r_last[a]  <= '0;
            end
        end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (i_cmd.pass || i_cmd.teleport) begin
                    r_pos[a] <= {ptr[a], {FRAC_BITS{1'b0}}};
                end
                if (i_cmd.impulse) begin
                    r_speed[a] <= sat_speed(isum[a]);
                end
                if (i_cmd.acc) begin
                    r_speed[a] <= sat_speed(ssum[a]);
                end
                if (i_cmd.upd) begin
                    r_pos[a]   <= clamped[a][POS_BITS-1:0];
                    r_speed[a] <= dragged[a];
                end
                if (i_cmd.upd_last) begin
                    r_last[a] <= cur_int[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (i_cmd.start_mul) begin
                r_neg[a]  <= delta[a][MAG_BITS-1];
                r_prod[a] <= prod[a];
            end
            if (i_cmd.mul2) begin
                r_acc[a] <= full[a][FULL_BITS-1:FRAC_BITS];
            end
            if (i_cmd.load_out) begin
                r_cur[a] <= cur_int[a];
            end
        end
        if (i_cmd.load_out) begin
            r_moving <= (r_speed[0] != '0) || (r_speed[1] != '0);
        end
    end

    assign o_cursor_x = r_cur[0];
    assign o_cursor_y = r_cur[1];
    assign o_moving   = r_moving;

endmodule

// ----- sv/inertial_cursor_with_drag.sv -----
// Inertial cursor filter for x and y. Items are taken one at a time: a tick in
// inertial mode passes through accept with the delta-times-time product, a second
// multiply by the gain, the speed update, the move with drag and clamp, then the
// result load; pass-through ticks, impulses, teleports and unused op codes go from
// accept straight to the result load. The result sits in an output register, so
// the next item is accepted while it waits. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
module inertial_cursor_with_drag (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [icd_pkg::OP_BITS-1:0]           i_op,
    input  logic [icd_pkg::TD_BITS-1:0]           i_time_diff,
    input  logic signed [icd_pkg::COORD_BITS-1:0] i_pointer_x,
    input  logic signed [icd_pkg::COORD_BITS-1:0] i_pointer_y,
    input  logic signed [icd_pkg::IMP_BITS-1:0]   i_impulse_x,
    input  logic signed [icd_pkg::IMP_BITS-1:0]   i_impulse_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [icd_pkg::COORD_BITS-1:0] o_cursor_x,
    output logic signed [icd_pkg::COORD_BITS-1:0] o_cursor_y,
    output logic                                  o_moving,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [icd_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [icd_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import icd_pkg::*;

    t_cfg cfg;
    t_cmd cmd;

    icd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    icd_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_op             (i_op),
        .i_physics_enable (cfg.physics_enable),
        .o_cmd            (cmd)
    );

    icd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_time_diff (i_time_diff),
        .i_pointer_x (i_pointer_x),
        .i_pointer_y (i_pointer_y),
        .i_impulse_x (i_impulse_x),
        .i_impulse_y (i_impulse_y),
        .o_cursor_x  (o_cursor_x),
        .o_cursor_y  (o_cursor_y),
        .o_moving    (o_moving)
    );

endmodule

// ----- sv/icd_chk.sv -----
module icd_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [icd_pkg::COORD_BITS-1:0] o_cursor_x,
    input logic signed [icd_pkg::COORD_BITS-1:0] o_cursor_y,
    input logic                                  o_moving
);

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while previous item still in work");

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> ($stable(o_cursor_x) && $stable(o_cursor_y) && $stable(o_moving)))
        else $error("stalled result changed");

endmodule

bind inertial_cursor_with_drag icd_chk u_icd_chk (.*);
